>>> design/pdema_pkg.sv
// ---------------------------------------------------------------------------
// pdema_pkg: shared types and constants of the PD position controller
// Item structs, register indexes, sequencer states, control bundles and the
// saturating helpers used by the datapath and the shared multiply unit.
// ---------------------------------------------------------------------------
`default_nettype none

package pdema_pkg;

    // Fixed point format of all signed values
    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 4;

    // EMA weights are unsigned Q1.16 regardless of the data format
    localparam int              EMA_SHIFT = 16;
    localparam logic [16:0]     ALPHA_MAX = 17'd65529;
    localparam logic [16:0]     ALPHA_ONE = 17'd65536;

    // 2*pi in Q3.30, rounded to FRAC_BITS fraction bits
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] TWO_PI_WIDE =
        (TWO_PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam logic signed [WORD_W-1:0] TWO_PI_Q = TWO_PI_WIDE[WORD_W-1:0];

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSITION_MODE   = 4'd0,
        CFG_WHEEL_RADIUS    = 4'd1,
        CFG_POSITION_TARGET = 4'd2,
        CFG_EMA_ALPHA       = 4'd3,
        CFG_GAIN_P          = 4'd4,
        CFG_GAIN_EMA        = 4'd5,
        CFG_GAIN_D          = 4'd6,
        CFG_VELOCITY_LIMIT  = 4'd7
    } cfg_index_t;

    // Input item
    typedef struct packed {
        logic signed [WORD_W-1:0] wheel_turns;
        logic                     wheel_turns_ok;
        logic signed [WORD_W-1:0] wheel_speed;
        logic signed [WORD_W-1:0] teleop_speed;
        logic                     trust;
        logic                     reanchor;
        logic signed [WORD_W-1:0] new_offset;
        logic signed [WORD_W-1:0] frozen_position;
        logic                     zero_request;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [WORD_W-1:0] speed_ref;
        logic signed [WORD_W-1:0] position;
        logic signed [WORD_W-1:0] error_average;
        logic                     in_position_mode;
    } out_item_t;

    // Sequencer states, one per cycle of the control tick unless waiting in S_IDLE or S_OUT
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TP_MUL,
        S_TP_RND,
        S_RAD_MUL,
        S_RAD_RND,
        S_ERR,
        S_EMA_MUL,
        S_EMA_RND,
        S_AVG,
        S_KEMA,
        S_KD,
        S_SUM,
        S_CLAMP,
        S_OUT
    } seq_state_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        OP_D_TWOPI,
        OP_RES_RADIUS,
        OP_ALPHA_AVG,
        OP_BETA_ERR,
        OP_KP_ERR,
        OP_KEMA_RES,
        OP_KD_SPEED
    } op_sel_t;

    // Velocity reference register operations
    typedef enum logic [2:0] {
        VREF_HOLD,
        VREF_LOAD,
        VREF_ADD,
        VREF_SUB,
        VREF_CLAMP
    } vref_op_t;

    // Controls of the shared multiply unit
    typedef struct packed {
        logic mul_en;   // capture a product
        logic acc_load; // park product plus rounding half
        logic rnd_en;   // round and saturate into result
        logic rnd_ema;  // round acc + product by EMA_SHIFT
    } mac_ctrl_t;

    // Sequencer to datapath bundle
    typedef struct packed {
        mac_ctrl_t mac;
        op_sel_t   op;
        vref_op_t  vref_op;
        logic      in_ready;
        logic      check;
        logic      ld_err;
        logic      ld_avg;
        logic      out_load;
    } seq_ctrl_t;

    // Saturate a wide signed value to one word
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [64:0] v);
        logic signed [WORD_W-1:0] r;
        if (v[64:WORD_W-1] == '0 || v[64:WORD_W-1] == '1)
            r = v[WORD_W-1:0];
        else if (v[64])
            r = {1'b1, {(WORD_W-1){1'b0}}};
        else
            r = {1'b0, {(WORD_W-1){1'b1}}};
        return r;
    endfunction

    // Saturating add
    function automatic logic signed [WORD_W-1:0] sadd(input logic signed [WORD_W-1:0] a,
                                                      input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return sat_word(65'(s));
    endfunction

    // Saturating subtract
    function automatic logic signed [WORD_W-1:0] ssub(input logic signed [WORD_W-1:0] a,
                                                      input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        return sat_word(65'(s));
    endfunction

endpackage

`default_nettype wire

>>> design/pdema_mac.sv
// ---------------------------------------------------------------------------
// pdema_mac: shared multiply, accumulate and round unit
// One 32x32 signed multiplier with a product register, a one-entry
// accumulator for the EMA sum and a round-to-nearest saturating result stage.
// ---------------------------------------------------------------------------
`default_nettype none

module pdema_mac (
    input  wire logic                                    clk,
    input  wire pdema_pkg::mac_ctrl_t                    ctrl,
    input  wire logic signed [pdema_pkg::WORD_W-1:0]     op_a,
    input  wire logic signed [pdema_pkg::WORD_W-1:0]     op_b,
    output logic signed [pdema_pkg::WORD_W-1:0]          res
);
    import pdema_pkg::*;

    localparam logic signed [64:0] Q_HALF   = 65'(65'd1 << (FRAC_BITS - 1));
    localparam logic signed [64:0] EMA_HALF = 65'(65'd1 << (EMA_SHIFT - 1));

    logic signed [63:0]       prod_reg;
    logic signed [64:0]       acc_reg;
    logic signed [WORD_W-1:0] res_reg;
    logic signed [64:0]       rnd_sum;
    logic signed [64:0]       rnd_shift;

    // Product register
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= 64'(op_a) * 64'(op_b);
        end
    end

    // Accumulator holds first EMA product with the rounding half folded in
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_load)
        begin
            acc_reg <= 65'(prod_reg) + EMA_HALF;
        end
    end

    // Rounding: add half, arithmetic shift (floor), saturate
    always_comb
    begin
        if (ctrl.rnd_ema)
        begin
            rnd_sum   = acc_reg + 65'(prod_reg);
            rnd_shift = rnd_sum >>> EMA_SHIFT;
        end
        else
        begin
            rnd_sum   = 65'(prod_reg) + Q_HALF;
            rnd_shift = rnd_sum >>> FRAC_BITS;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctrl.rnd_en)
        begin
            res_reg <= sat_word(rnd_shift);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> design/pdema_seq.sv
// ---------------------------------------------------------------------------
// pdema_seq: control tick sequencer
// Steps the shared multiply unit through the position, EMA and PD terms and
// drives the datapath loads, one state per cycle outside the input and output waits.
// ---------------------------------------------------------------------------
`default_nettype none

module pdema_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 run,
    input  wire logic                 out_free,
    output pdema_pkg::seq_ctrl_t      ctrl
);
    import pdema_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and controls
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.op    = OP_D_TWOPI;
        ctrl.vref_op = VREF_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctrl.check = 1'b1;
                state_next = run ? S_TP_MUL : S_OUT;
            end
            S_TP_MUL:
            begin
                ctrl.op         = OP_D_TWOPI;
                ctrl.mac.mul_en = 1'b1;
                state_next      = S_TP_RND;
            end
            S_TP_RND:
            begin
                ctrl.mac.rnd_en = 1'b1;
                state_next      = S_RAD_MUL;
            end
            S_RAD_MUL:
            begin
                ctrl.op         = OP_RES_RADIUS;
                ctrl.mac.mul_en = 1'b1;
                state_next      = S_RAD_RND;
            end
            S_RAD_RND:
            begin
                ctrl.mac.rnd_en = 1'b1;
                state_next      = S_ERR;
            end
            S_ERR:
            begin
                // error from position; start alpha * old average
                ctrl.ld_err     = 1'b1;
                ctrl.op         = OP_ALPHA_AVG;
                ctrl.mac.mul_en = 1'b1;
                state_next      = S_EMA_MUL;
            end
            S_EMA_MUL:
            begin
                ctrl.op           = OP_BETA_ERR;
                ctrl.mac.mul_en   = 1'b1;
                ctrl.mac.acc_load = 1'b1;
                state_next        = S_EMA_RND;
            end
            S_EMA_RND:
            begin
                ctrl.mac.rnd_en  = 1'b1;
                ctrl.mac.rnd_ema = 1'b1;
                ctrl.op          = OP_KP_ERR;
                ctrl.mac.mul_en  = 1'b1;
                state_next       = S_AVG;
            end
            S_AVG:
            begin
                // new average stored; P term rounds; EMA term multiplies
                ctrl.ld_avg     = 1'b1;
                ctrl.mac.rnd_en = 1'b1;
                ctrl.op         = OP_KEMA_RES;
                ctrl.mac.mul_en = 1'b1;
                state_next      = S_KEMA;
            end
            S_KEMA:
            begin
                ctrl.vref_op    = VREF_LOAD;
                ctrl.mac.rnd_en = 1'b1;
                ctrl.op         = OP_KD_SPEED;
                ctrl.mac.mul_en = 1'b1;
                state_next      = S_KD;
            end
            S_KD:
            begin
                ctrl.vref_op    = VREF_ADD;
                ctrl.mac.rnd_en = 1'b1;
                state_next      = S_SUM;
            end
            S_SUM:
            begin
                ctrl.vref_op = VREF_SUB;
                state_next   = S_CLAMP;
            end
            S_CLAMP:
            begin
                ctrl.vref_op = VREF_CLAMP;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // wait for a free output register
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/position_to_velocity_pd_ema_core.sv
// ---------------------------------------------------------------------------
// position_to_velocity_pd_ema_core: PD position controller with EMA error
// Converts wheel turns to metres, tracks an averaged position error and
// forms a clamped velocity reference, or passes teleop speed through.
// ---------------------------------------------------------------------------
// One control tick is one transfer in and one transfer out. In position mode
// with a runnable loop (trust, valid turns, offset set, nonzero radius) the
// item runs the whole multiply sequence before its result is offered; every
// other item goes from the check straight to the output stage. All products
// run through a single 32x32 signed multiplier, used seven times in a running
// tick, so the next item is taken once the current one has moved into the
// output register. The output register lets a new item start while the
// previous result still waits; a result that cannot enter it stalls the
// sequencer. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); indexes above 7 are ignored. Values are signed Q16.16 with
// saturation of every intermediate.
`default_nettype none

module position_to_velocity_pd_ema_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  cfg_we,
    input  wire logic [pdema_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pdema_pkg::WORD_W-1:0]          cfg_data,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire pdema_pkg::in_item_t                   in_data,
    // output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output pdema_pkg::out_item_t                       out_data
);
    import pdema_pkg::*;

    // configuration registers
    logic                     mode_reg;
    logic [WORD_W-2:0]        radius_reg;
    logic signed [WORD_W-1:0] target_reg;
    logic [15:0]              alpha_reg;
    logic signed [WORD_W-1:0] kp_reg;
    logic signed [WORD_W-1:0] kema_reg;
    logic signed [WORD_W-1:0] kd_reg;
    logic [WORD_W-2:0]        vlim_reg;

    // tick state
    logic signed [WORD_W-1:0] offset_reg;
    logic signed [WORD_W-1:0] offset_next;
    logic                     offset_set_reg;
    logic                     offset_set_next;
    logic signed [WORD_W-1:0] avg_reg;
    logic signed [WORD_W-1:0] avg_next;

    // datapath
    in_item_t                 item_reg;
    logic signed [WORD_W-1:0] d_reg;
    logic signed [WORD_W-1:0] err_reg;
    logic signed [WORD_W-1:0] pos_reg;
    logic signed [WORD_W-1:0] vref_reg;
    out_item_t                out_data_reg;
    logic                     out_valid_reg;

    seq_ctrl_t                ctrl;
    logic                     in_take;
    logic                     run;
    logic                     out_free;
    logic signed [WORD_W-1:0] op_a;
    logic signed [WORD_W-1:0] op_b;
    logic signed [WORD_W-1:0] mac_res;
    logic [16:0]              alpha_c;
    logic [16:0]              beta;
    logic signed [WORD_W-1:0] vlim_s;
    logic signed [WORD_W-1:0] vlim_neg;

    assign in_ready = ctrl.in_ready;
    assign in_take  = in_valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign run      = mode_reg && item_reg.trust && item_reg.wheel_turns_ok &&
                      offset_set_reg && (radius_reg != '0);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            radius_reg <= '0;
            target_reg <= '0;
            alpha_reg  <= '0;
            kp_reg     <= '0;
            kema_reg   <= '0;
            kd_reg     <= '0;
            vlim_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POSITION_MODE:   mode_reg   <= cfg_data[0];
                CFG_WHEEL_RADIUS:    radius_reg <= cfg_data[WORD_W-2:0];
                CFG_POSITION_TARGET: target_reg <= cfg_data;
                CFG_EMA_ALPHA:       alpha_reg  <= cfg_data[15:0];
                CFG_GAIN_P:          kp_reg     <= cfg_data;
                CFG_GAIN_EMA:        kema_reg   <= cfg_data;
                CFG_GAIN_D:          kd_reg     <= cfg_data;
                CFG_VELOCITY_LIMIT:  vlim_reg   <= cfg_data[WORD_W-2:0];
                default:             ;
            endcase
        end
    end

    // offset anchoring on transfer, average update from the EMA step
    always_comb
    begin
        offset_next     = offset_reg;
        offset_set_next = offset_set_reg;
        avg_next        = avg_reg;
        if (in_take)
        begin
            if (in_data.reanchor && in_data.wheel_turns_ok)
            begin
                offset_next     = in_data.new_offset;
                offset_set_next = 1'b1;
                avg_next        = '0;
            end
            if ((in_data.zero_request || (mode_reg && !offset_set_next)) &&
                in_data.wheel_turns_ok)
            begin
                offset_next     = in_data.wheel_turns;
                offset_set_next = 1'b1;
                avg_next        = '0;
            end
        end
        if (ctrl.ld_avg)
        begin
            avg_next = mac_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            offset_set_reg <= 1'b0;
            avg_reg        <= '0;
        end
        else
        begin
            offset_reg     <= offset_next;
            offset_set_reg <= offset_set_next;
            avg_reg        <= avg_next;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
    end

    // EMA weights
    always_comb
    begin
        alpha_c  = ({1'b0, alpha_reg} > ALPHA_MAX) ? ALPHA_MAX : {1'b0, alpha_reg};
        beta     = ALPHA_ONE - alpha_c;
        vlim_s   = {1'b0, vlim_reg};
        vlim_neg = -vlim_s;
    end

    // multiplier operand select
    always_comb
    begin
        unique case (ctrl.op)
            OP_D_TWOPI:
            begin
                op_a = d_reg;
                op_b = TWO_PI_Q;
            end
            OP_RES_RADIUS:
            begin
                op_a = mac_res;
                op_b = {1'b0, radius_reg};
            end
            OP_ALPHA_AVG:
            begin
                op_a = {{(WORD_W-17){1'b0}}, alpha_c};
                op_b = avg_reg;
            end
            OP_BETA_ERR:
            begin
                op_a = {{(WORD_W-17){1'b0}}, beta};
                op_b = err_reg;
            end
            OP_KP_ERR:
            begin
                op_a = kp_reg;
                op_b = err_reg;
            end
            OP_KEMA_RES:
            begin
                op_a = kema_reg;
                op_b = mac_res;
            end
            OP_KD_SPEED:
            begin
                op_a = kd_reg;
                op_b = item_reg.wheel_speed;
            end
            default:
            begin
                op_a = d_reg;
                op_b = TWO_PI_Q;
            end
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.check)
        begin
            d_reg    <= ssub(item_reg.wheel_turns, offset_reg);
            pos_reg  <= (mode_reg && !item_reg.trust) ? item_reg.frozen_position : '0;
            vref_reg <= mode_reg ? '0 : item_reg.teleop_speed;
        end
        if (ctrl.ld_err)
        begin
            pos_reg <= mac_res;
            err_reg <= ssub(target_reg, mac_res);
        end
        unique case (ctrl.vref_op)
            VREF_HOLD:  ;
            VREF_LOAD:  vref_reg <= mac_res;
            VREF_ADD:   vref_reg <= sadd(vref_reg, mac_res);
            VREF_SUB:   vref_reg <= ssub(vref_reg, mac_res);
            VREF_CLAMP:
            begin
                if (vref_reg > vlim_s)
                    vref_reg <= vlim_s;
                else if (vref_reg < vlim_neg)
                    vref_reg <= vlim_neg;
            end
            default:    ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_data_reg.speed_ref        <= vref_reg;
            out_data_reg.position         <= pos_reg;
            out_data_reg.error_average    <= avg_reg;
            out_data_reg.in_position_mode <= mode_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // shared arithmetic unit
    pdema_mac u_mac (
        .clk  (clk),
        .ctrl (ctrl.mac),
        .op_a (op_a),
        .op_b (op_b),
        .res  (mac_res)
    );

    // sequencer
    pdema_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .run      (run),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

endmodule

`default_nettype wire
